@@ rtl/assert_macros.svh @@
// Assertion helpers. Every user has clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be true at a clock edge outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)

`endif

`endif

@@ rtl/ttdc_pkg.sv @@
package ttdc_pkg;

  // Stored texel formats
  typedef enum logic [2:0] {
    FMT_RGBA8888 = 3'd0,
    FMT_RGB888   = 3'd1,
    FMT_RGBA5551 = 3'd2,
    FMT_RGB565   = 3'd3,
    FMT_RGBA4444 = 3'd4
  } ttdc_fmt_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_PIXEL_FORMAT    = 2'd0,
    CFG_WIDTH_IN_TILES  = 2'd1,
    CFG_HEIGHT_IN_TILES = 2'd2
  } ttdc_cfg_e;

  localparam int unsigned MAX_TILES_PER_SIDE_DEF = 128;
  localparam int unsigned QUEUE_DEPTH            = 2;
  localparam int unsigned TEXEL_W                = 32;
  localparam int unsigned COORD_W                = 10;
  localparam int unsigned CFG_DATA_W             = 8;
  localparam int unsigned TILE_IDX_W             = 6;
  localparam logic [TILE_IDX_W-1:0] TILE_LAST_IDX = '1;

  // Reciprocals for floor(n / 31) and floor(n / 63) by multiply and shift
  localparam logic [13:0] RECIP_31 = 14'd8457;
  localparam logic [14:0] RECIP_63 = 15'd16645;

  // Classified word handed from the front to the back
  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic               last_texel;
    logic [TEXEL_W-1:0] texel_bits;
  } ttdc_entry_t;

  // floor(v * 255 / 31)
  function automatic logic [7:0] expand5(input logic [4:0] v);
    logic [12:0] n;
    logic [26:0] p;
    n = {v, 8'd0} - {8'd0, v};
    p = n * RECIP_31;
    return p[25:18];
  endfunction

  // floor(v * 255 / 63)
  function automatic logic [7:0] expand6(input logic [5:0] v);
    logic [13:0] n;
    logic [28:0] p;
    n = {v, 8'd0} - {8'd0, v};
    p = n * RECIP_63;
    return p[27:20];
  endfunction

endpackage

@@ rtl/ttdc_front.sv @@
`include "assert_macros.svh"

module ttdc_front #(
  parameter int unsigned MAX_TILES_PER_SIDE = ttdc_pkg::MAX_TILES_PER_SIDE_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  logic [ttdc_pkg::TEXEL_W-1:0]      texel_bits_i,
  input  logic [ttdc_pkg::CFG_DATA_W-1:0]   width_in_tiles_i,
  input  logic [ttdc_pkg::CFG_DATA_W-1:0]   height_in_tiles_i,
  output ttdc_pkg::ttdc_entry_t             entry_o
);
  import ttdc_pkg::*;

  localparam int unsigned CW  = (MAX_TILES_PER_SIDE > 1) ? $clog2(MAX_TILES_PER_SIDE) : 1;
  localparam int unsigned NW0 = $clog2(MAX_TILES_PER_SIDE + 1);
  localparam int unsigned NW  = ((NW0 > CFG_DATA_W) ? NW0 : CFG_DATA_W) + 1;
  localparam logic [NW-1:0] MaxTiles = NW'(MAX_TILES_PER_SIDE);

  logic [TILE_IDX_W-1:0] idx_q, idx_d;
  logic [CW-1:0]         col_q, col_d, row_q, row_d;
  logic [NW-1:0]         w_eff, h_eff, col_next, row_next;
  logic [2:0]            x_off, y_off;
  logic [CW+2:0]         px_full, py_full;
  logic                  col_end, row_end, tile_end;

  function automatic logic [NW-1:0] clamp_tiles(input logic [CFG_DATA_W-1:0] n);
    logic [NW-1:0] r;
    r = NW'(n);
    if (n == '0) r = NW'(1);
    else if (r > MaxTiles) r = MaxTiles;
    return r;
  endfunction

  always_comb begin
    w_eff    = clamp_tiles(width_in_tiles_i);
    h_eff    = clamp_tiles(height_in_tiles_i);
    col_next = NW'(col_q) + NW'(1);
    row_next = NW'(row_q) + NW'(1);
    col_end  = col_next >= w_eff;
    row_end  = row_next >= h_eff;
    tile_end = idx_q == TILE_LAST_IDX;
    // de-interleave Morton index: x on even bits, y on odd bits
    x_off    = {idx_q[4], idx_q[2], idx_q[0]};
    y_off    = {idx_q[5], idx_q[3], idx_q[1]};
    px_full  = {col_q, x_off};
    py_full  = {row_q, y_off};

    entry_o.pixel_x    = COORD_W'(px_full);
    entry_o.pixel_y    = COORD_W'(py_full);
    entry_o.last_texel = tile_end && col_end && row_end;
    entry_o.texel_bits = texel_bits_i;

    idx_d = idx_q;
    col_d = col_q;
    row_d = row_q;
    if (accept_i) begin
      idx_d = idx_q + TILE_IDX_W'(1);
      if (tile_end) begin
        if (col_end) begin
          col_d = '0;
          row_d = row_end ? '0 : CW'(row_next);
        end else begin
          col_d = CW'(col_next);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      col_q <= '0;
      row_q <= '0;
    end else begin
      idx_q <= idx_d;
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  `ASSERT_ALWAYS(a_last_restarts,
    accept_i && entry_o.last_texel |=> idx_q == '0 && col_q == '0 && row_q == '0,
    "walk does not restart after the last texel")
  `ASSERT_ALWAYS(a_col_in_range, NW'(col_q) < MaxTiles, "tile column beyond limit")
  `ASSERT_ALWAYS(a_row_in_range, NW'(row_q) < MaxTiles, "tile row beyond limit")

endmodule

@@ rtl/ttdc_queue.sv @@
`include "assert_macros.svh"

module ttdc_queue #(
  parameter int unsigned DEPTH = ttdc_pkg::QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  ttdc_pkg::ttdc_entry_t push_data_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  avail_o,
  output ttdc_pkg::ttdc_entry_t pop_data_o
);
  import ttdc_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LastSlot = PW'(DEPTH - 1);
  localparam logic [NW-1:0] Depth    = NW'(DEPTH);

  ttdc_entry_t       slot_q [DEPTH];
  logic [PW-1:0]     wr_q, rd_q;
  logic [NW-1:0]     cnt_q, cnt_d;

  assign full_o     = cnt_q == Depth;
  assign avail_o    = cnt_q != '0;
  assign pop_data_o = slot_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + NW'(1);
    else if (pop_i && !push_i) cnt_d = cnt_q - NW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wr_q <= (wr_q == LastSlot) ? '0 : wr_q + PW'(1);
      if (pop_i)  rd_q <= (rd_q == LastSlot) ? '0 : rd_q + PW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= push_data_i;
  end

  `ASSERT_NEVER(a_no_overflow, push_i && full_o, "push into a full queue")
  `ASSERT_NEVER(a_no_underflow, pop_i && !avail_o, "pop from an empty queue")
  `ASSERT_ALWAYS(a_cnt_bound, cnt_q <= Depth, "queue count beyond depth")

endmodule

@@ rtl/ttdc_back.sv @@
module ttdc_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ttdc_pkg::ttdc_fmt_e               pixel_format_i,
  input  logic                              avail_i,
  input  ttdc_pkg::ttdc_entry_t             entry_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [ttdc_pkg::COORD_W-1:0]      pixel_x_o,
  output logic [ttdc_pkg::COORD_W-1:0]      pixel_y_o,
  output logic [7:0]                        out_byte0_o,
  output logic [7:0]                        out_byte1_o,
  output logic [7:0]                        out_byte2_o,
  output logic [7:0]                        out_byte3_o,
  output logic                              last_texel_o
);
  import ttdc_pkg::*;

  logic        valid_q;
  logic [7:0]  b0, b1, b2, b3, r_d, g_d, bl_d, a_d;
  logic [15:0] v;
  logic [COORD_W-1:0] x_q, y_q;
  logic [7:0]  r_q, g_q, bl_q, a_q;
  logic        last_q;

  // advance when the output register is empty or being taken
  assign pop_o = avail_i && (!valid_q || !out_stall_i);

  always_comb begin
    b0 = entry_i.texel_bits[7:0];
    b1 = entry_i.texel_bits[15:8];
    b2 = entry_i.texel_bits[23:16];
    b3 = entry_i.texel_bits[31:24];
    v  = {b1, b0};
    case (pixel_format_i)
      FMT_RGB888: begin
        r_d = b2; g_d = b1; bl_d = b0; a_d = 8'hFF;
      end
      FMT_RGBA5551: begin
        r_d  = expand5(v[15:11]);
        g_d  = expand5(v[10:6]);
        bl_d = expand5(v[5:1]);
        a_d  = v[0] ? 8'hFF : 8'h00;
      end
      FMT_RGB565: begin
        r_d  = expand5(v[15:11]);
        g_d  = expand6(v[10:5]);
        bl_d = expand5(v[4:0]);
        a_d  = 8'hFF;
      end
      FMT_RGBA4444: begin
        r_d = {v[15:12], v[15:12]}; g_d = {v[11:8], v[11:8]};
        bl_d = {v[7:4], v[7:4]};    a_d = {v[3:0], v[3:0]};
      end
      default: begin
        r_d = b0; g_d = b1; bl_d = b2; a_d = b3;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || !out_stall_i) begin
      valid_q <= avail_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      x_q    <= entry_i.pixel_x;
      y_q    <= entry_i.pixel_y;
      last_q <= entry_i.last_texel;
      r_q    <= r_d;
      g_q    <= g_d;
      bl_q   <= bl_d;
      a_q    <= a_d;
    end
  end

  assign out_valid_o  = valid_q;
  assign pixel_x_o    = x_q;
  assign pixel_y_o    = y_q;
  assign out_byte0_o  = r_q;
  assign out_byte1_o  = g_q;
  assign out_byte2_o  = bl_q;
  assign out_byte3_o  = a_q;
  assign last_texel_o = last_q;

endmodule

@@ rtl/tiled_texel_detile_convert_core.sv @@
// Path: an accepted word is written into the queue, then moves into the back's output
//   register, from which it is presented and can be taken at the output.
// Throughput: one word per cycle sustained while the output is not stalled; the two-entry
//   queue between the detile front and the convert back lets each side stall on its own.
// Reset (rst_ni, async, active low): walk restarts at texel 0 of tile 0,0, queue
//   and output register empty, format RGBA8888, image 1x1 tiles.
module tiled_texel_detile_convert_core #(
  parameter int unsigned MAX_TILES_PER_SIDE = ttdc_pkg::MAX_TILES_PER_SIDE_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration writes
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_idx_i,
  input  logic [ttdc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // texel words in stored order
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [ttdc_pkg::TEXEL_W-1:0]    texel_bits_i,
  // pixel words in linear form
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [ttdc_pkg::COORD_W-1:0]    pixel_x_o,
  output logic [ttdc_pkg::COORD_W-1:0]    pixel_y_o,
  output logic [7:0]                      out_byte0_o,
  output logic [7:0]                      out_byte1_o,
  output logic [7:0]                      out_byte2_o,
  output logic [7:0]                      out_byte3_o,
  output logic                            last_texel_o
);
  import ttdc_pkg::*;

  logic [2:0]            fmt_q;
  logic [CFG_DATA_W-1:0] width_q, height_q;
  logic                  accept, q_full, q_avail, q_pop;
  ttdc_entry_t           front_entry, back_entry;

  // Configuration registers, to be written only while the block is idle (a user's rule
  // not enforced by the block), so front and back read them directly with no shadow copies.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= FMT_RGBA8888;
      width_q  <= CFG_DATA_W'(1);
      height_q <= CFG_DATA_W'(1);
    end else if (cfg_we_i) begin
      case (ttdc_cfg_e'(cfg_idx_i))
        CFG_PIXEL_FORMAT:    fmt_q    <= cfg_wdata_i[2:0];
        CFG_WIDTH_IN_TILES:  width_q  <= cfg_wdata_i;
        CFG_HEIGHT_IN_TILES: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Hold the input side only while the queue is full; this never looks at
  // out_stall_i, so the two channels have no combinational path between them.
  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  // Front: walk the tile counters, de-interleave the Morton index and flag
  // the last texel of the image.
  ttdc_front #(
    .MAX_TILES_PER_SIDE(MAX_TILES_PER_SIDE)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .texel_bits_i     (texel_bits_i),
    .width_in_tiles_i (width_q),
    .height_in_tiles_i(height_q),
    .entry_o          (front_entry)
  );

  // Short queue decoupling the front from the back
  ttdc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .push_data_i(front_entry),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .avail_o    (q_avail),
    .pop_data_o (back_entry)
  );

  // Back: convert the stored format and register the result word
  ttdc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pixel_format_i(ttdc_fmt_e'(fmt_q)),
    .avail_i       (q_avail),
    .entry_i       (back_entry),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .out_byte0_o   (out_byte0_o),
    .out_byte1_o   (out_byte1_o),
    .out_byte2_o   (out_byte2_o),
    .out_byte3_o   (out_byte3_o),
    .last_texel_o  (last_texel_o)
  );

endmodule
